FILE: sv/cttok_pkg.sv
// Package for the configuration text tokenizer.
// Event, token and mode codes, the queued job record and position constants.
// No dependencies.
package cttok_pkg;

  localparam int POS_WIDTH = 16;
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [POS_WIDTH-1:0] POS_ONE = {{(POS_WIDTH-1){1'b0}}, 1'b1};
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW = $clog2(JQ_DEPTH);
  localparam int MAX_EV = 4;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    EV_BEGIN = 2'd0,
    EV_TEXT  = 2'd1,
    EV_END   = 2'd2,
    EV_EOI   = 2'd3
  } ev_kind_t;

  typedef enum logic [2:0] {
    TT_IDENT  = 3'd0,
    TT_STRING = 3'd1,
    TT_LBRACE = 3'd2,
    TT_RBRACE = 3'd3,
    TT_SEMI   = 3'd4
  } tok_type_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_ESCAPE  = 3'd4
  } mode_t;

  typedef struct packed {
    ev_kind_t  kind;
    tok_type_t ttype;
    logic [7:0] tbyte;
  } event_t;

  // one accepted byte's worth of events; position is shared by begin / EOI
  typedef struct packed {
    logic [2:0]            n;
    event_t [MAX_EV-1:0]   ev;
    logic [POS_WIDTH-1:0]  line;
    logic [POS_WIDTH-1:0]  col;
  } job_t;

  function automatic event_t mk_ev(ev_kind_t k, tok_type_t t, logic [7:0] b);
    event_t e;
    e.kind = k;
    e.ttype = t;
    e.tbyte = b;
    return e;
  endfunction

endpackage

FILE: sv/cttok_front.sv
// Tokenizer front: accepts bytes, tracks mode, line and column, and builds
// one job of up to four events per byte. Depends on cttok_pkg.
module cttok_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              eot_i,
  output logic              push_o,
  output cttok_pkg::job_t   job_o
);
  import cttok_pkg::*;

  mode_t mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [POS_WIDTH-1:0] col_inc, line_inc;
  logic is_ident, is_blank, is_lf, is_quote, is_bs;
  mode_t idle_mode;
  tok_type_t single_tt;
  logic do_idle;
  job_t job_c;

  assign is_ident = (byte_i >= 8'h30 && byte_i <= 8'h39) ||
                    (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                    (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                    byte_i == 8'h5F || byte_i == 8'h2E || byte_i == 8'h2F ||
                    byte_i == 8'h2D || byte_i == 8'h3A;
  assign is_blank = byte_i == CH_SPACE || byte_i == CH_TAB || byte_i == CH_CR;
  assign is_lf    = byte_i == CH_LF;
  assign is_quote = byte_i == CH_QUOTE;
  assign is_bs    = byte_i == CH_BSLASH;
  assign col_inc  = (col_r == POS_MAX) ? col_r : col_r + POS_ONE;
  assign line_inc = (line_r == POS_MAX) ? line_r : line_r + POS_ONE;

  always_comb begin
    if (byte_i == CH_HASH) begin
      idle_mode = MODE_COMMENT;
    end else if (is_quote) begin
      idle_mode = MODE_STRING;
    end else if (is_ident) begin
      idle_mode = MODE_IDENT;
    end else begin
      idle_mode = MODE_IDLE;
    end
  end

  always_comb begin
    if (byte_i == CH_LBRACE) begin
      single_tt = TT_LBRACE;
    end else if (byte_i == CH_RBRACE) begin
      single_tt = TT_RBRACE;
    end else begin
      single_tt = TT_SEMI;
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    if (eot_i) begin
      mode_nxt = MODE_IDLE;
    end else begin
      case (mode_r)
        MODE_COMMENT: mode_nxt = is_lf ? MODE_IDLE : MODE_COMMENT;
        MODE_IDENT:   mode_nxt = is_ident ? MODE_IDENT : idle_mode;
        MODE_STRING: begin
          if (is_quote) begin
            mode_nxt = MODE_IDLE;
          end else if (is_bs) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            mode_nxt = MODE_STRING;
          end
        end
        MODE_ESCAPE:  mode_nxt = MODE_STRING;
        default:      mode_nxt = idle_mode;
      endcase
    end
  end

  // events and positions
  always_comb begin
    job_c = '0;
    job_c.line = line_r;
    job_c.col = col_r;
    line_nxt = line_r;
    col_nxt = col_r;
    do_idle = 1'b0;
    if (eot_i) begin
      case (mode_r)
        MODE_IDENT: begin
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_END, TT_IDENT, 8'h00);
          job_c.n = job_c.n + 3'd1;
        end
        MODE_STRING: begin
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_END, TT_STRING, 8'h00);
          job_c.n = job_c.n + 3'd1;
        end
        MODE_ESCAPE: begin
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_TEXT, TT_STRING, CH_BSLASH);
          job_c.n = job_c.n + 3'd1;
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_END, TT_STRING, 8'h00);
          job_c.n = job_c.n + 3'd1;
        end
        default: ;
      endcase
      job_c.ev[job_c.n[1:0]] = mk_ev(EV_EOI, TT_IDENT, 8'h00);
      job_c.n = job_c.n + 3'd1;
    end else begin
      case (mode_r)
        MODE_COMMENT: begin
          if (is_lf) begin
            line_nxt = line_inc;
            col_nxt = POS_ONE;
          end else begin
            col_nxt = col_inc;
          end
        end
        MODE_IDENT: begin
          if (is_ident) begin
            job_c.ev[job_c.n[1:0]] = mk_ev(EV_TEXT, TT_IDENT, byte_i);
            job_c.n = job_c.n + 3'd1;
            col_nxt = col_inc;
          end else begin
            job_c.ev[job_c.n[1:0]] = mk_ev(EV_END, TT_IDENT, 8'h00);
            job_c.n = job_c.n + 3'd1;
            do_idle = 1'b1;
          end
        end
        MODE_STRING: begin
          if (is_quote) begin
            job_c.ev[job_c.n[1:0]] = mk_ev(EV_END, TT_STRING, 8'h00);
            job_c.n = job_c.n + 3'd1;
          end else if (!is_bs) begin
            job_c.ev[job_c.n[1:0]] = mk_ev(EV_TEXT, TT_STRING, byte_i);
            job_c.n = job_c.n + 3'd1;
          end
          col_nxt = col_inc;
        end
        MODE_ESCAPE: begin
          if (!is_quote && !is_bs) begin
            job_c.ev[job_c.n[1:0]] = mk_ev(EV_TEXT, TT_STRING, CH_BSLASH);
            job_c.n = job_c.n + 3'd1;
          end
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_TEXT, TT_STRING, byte_i);
          job_c.n = job_c.n + 3'd1;
          col_nxt = col_inc;
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        if (is_lf) begin
          line_nxt = line_inc;
          col_nxt = POS_ONE;
        end else if (is_blank || byte_i == CH_HASH) begin
          col_nxt = col_inc;
        end else if (byte_i == CH_LBRACE || byte_i == CH_RBRACE ||
                     byte_i == CH_SEMI) begin
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_BEGIN, single_tt, 8'h00);
          job_c.n = job_c.n + 3'd1;
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_END, single_tt, 8'h00);
          job_c.n = job_c.n + 3'd1;
          col_nxt = col_inc;
        end else if (is_quote) begin
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_BEGIN, TT_STRING, 8'h00);
          job_c.n = job_c.n + 3'd1;
          col_nxt = col_inc;
        end else begin
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_BEGIN, TT_IDENT, 8'h00);
          job_c.n = job_c.n + 3'd1;
          job_c.ev[job_c.n[1:0]] = mk_ev(EV_TEXT, TT_IDENT, byte_i);
          job_c.n = job_c.n + 3'd1;
          if (!is_ident) begin
            // stray byte: one-byte identifier
            job_c.ev[job_c.n[1:0]] = mk_ev(EV_END, TT_IDENT, 8'h00);
            job_c.n = job_c.n + 3'd1;
          end
          col_nxt = col_inc;
        end
      end
    end
  end

  assign job_o  = job_c;
  assign push_o = accept_i && (job_c.n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      line_r <= POS_ONE;
      col_r  <= POS_ONE;
    end else if (accept_i) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

FILE: sv/cttok_jobq.sv
// Short job queue between tokenizer front and back.
// Register array with read and write pointers. Depends on cttok_pkg.
module cttok_jobq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  cttok_pkg::job_t   job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output cttok_pkg::job_t   head_o
);
  import cttok_pkg::*;

  job_t mem [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [JQ_AW:0]   cnt_r, cnt_nxt;

  assign full_o  = cnt_r == (JQ_AW+1)'(JQ_DEPTH);
  assign empty_o = cnt_r == '0;
  assign head_o  = mem[rd_r];

  always_comb begin
    wr_nxt = push_i ? wr_r + 1'b1 : wr_r;
    rd_nxt = pop_i ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (JQ_AW+1)'(push_i) - (JQ_AW+1)'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_r] <= job_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (JQ_AW+1)'(JQ_DEPTH))
    else $error("job queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("pop from empty job queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_i && !pop_i |-> !full_o)
    else $error("push into full job queue");
  a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> job_i.n != 3'd0 && job_i.n <= 3'(MAX_EV))
    else $error("bad job event count");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push_i && !pop_i |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("job queue count did not advance");
`endif

endmodule

FILE: sv/cttok_back.sv
// Tokenizer back: walks the events of the head job one per cycle, while the
// result is popped or empty, into the result register. Uses cttok_pkg.
module cttok_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty_i,
  input  cttok_pkg::job_t                 head_i,
  output logic                            q_pop_o,
  input  logic                            pop_i,
  output logic                            valid_o,
  output logic [1:0]                      kind_o,
  output logic [2:0]                      ttype_o,
  output logic [cttok_pkg::POS_WIDTH-1:0] line_o,
  output logic [cttok_pkg::POS_WIDTH-1:0] col_o,
  output logic [7:0]                      tbyte_o,
  output logic                            last_o
);
  import cttok_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic valid_r, valid_nxt;
  logic load, last_ev, has_pos;
  event_t ev;
  ev_kind_t kind_r;
  tok_type_t ttype_r;
  logic [POS_WIDTH-1:0] line_r, col_r;
  logic [7:0] tbyte_r;
  logic last_r;

  assign load    = (!valid_r || pop_i) && !q_empty_i;
  assign ev      = head_i.ev[idx_r];
  assign last_ev = ({1'b0, idx_r} + 3'd1) == head_i.n;
  assign has_pos = ev.kind == EV_BEGIN || ev.kind == EV_EOI;
  assign q_pop_o = load && last_ev;

  always_comb begin
    idx_nxt = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt = last_ev ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (pop_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= ev.kind;
      ttype_r <= ev.ttype;
      tbyte_r <= ev.tbyte;
      line_r  <= has_pos ? head_i.line : '0;
      col_r   <= has_pos ? head_i.col : '0;
      last_r  <= last_ev;
    end
  end

  assign valid_o = valid_r;
  assign kind_o  = kind_r;
  assign ttype_o = ttype_r;
  assign line_o  = line_r;
  assign col_o   = col_r;
  assign tbyte_o = tbyte_r;
  assign last_o  = last_r;

`ifndef NO_ASSERTIONS
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty_i |-> {1'b0, idx_r} < head_i.n)
    else $error("event index past end of job");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !pop_i |=> valid_r && $stable(kind_r) && $stable(tbyte_r))
    else $error("result changed while stalled");
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop_o |-> last_ev)
    else $error("job retired before its last event");
`endif

endmodule

FILE: sv/config_text_tokenizer.sv
// Top level of the configuration text tokenizer: front, job queue and back.
// Depends on cttok_pkg, cttok_front, cttok_jobq, cttok_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   input    | push / full        | in_byte, in_end_of_text
//   result   | empty / pop        | out_event_kind, out_token_type,
//            |                    | out_start_line, out_start_column,
//            |                    | out_text_byte, out_last_result
//
// A byte is taken at every edge while the four-entry job queue has room.
// Each byte yields zero to four words, sent one per cycle by the back stage
// while the result is popped or empty. With the back stage idle, the first
// word passes from its byte through the job queue into the result register.
// Reset: mode between tokens, line and column 1, queues empty.
// full rises when the job queue fills: behind a stalled pop, or behind a run
// of bytes that yield more than one word each.
module config_text_tokenizer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      in_byte,
  input  logic                            in_end_of_text,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      out_event_kind,
  output logic [2:0]                      out_token_type,
  output logic [cttok_pkg::POS_WIDTH-1:0] out_start_line,
  output logic [cttok_pkg::POS_WIDTH-1:0] out_start_column,
  output logic [7:0]                      out_text_byte,
  output logic                            out_last_result
);
  import cttok_pkg::*;

  logic accept, f_push, q_full, q_empty, q_pop, b_valid;
  job_t f_job, q_head;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = !b_valid;

  cttok_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .byte_i   (in_byte),
    .eot_i    (in_end_of_text),
    .push_o   (f_push),
    .job_o    (f_job)
  );

  cttok_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (f_push),
    .job_i   (f_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  cttok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty_i (q_empty),
    .head_i    (q_head),
    .q_pop_o   (q_pop),
    .pop_i     (pop && b_valid),
    .valid_o   (b_valid),
    .kind_o    (out_event_kind),
    .ttype_o   (out_token_type),
    .line_o    (out_start_line),
    .col_o     (out_start_column),
    .tbyte_o   (out_text_byte),
    .last_o    (out_last_result)
  );

endmodule

FILE: test/tb.sv
// Testbench for config_text_tokenizer: byte stream in, token events out.
// A scoreboard class predicts the words caused by each accepted byte and checks
// every popped word in order. Depends on cttok_pkg and the tokenizer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cttok_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef struct {
    ev_kind_t   kind;
    tok_type_t  ttype;
    pos_t       line;
    pos_t       col;
    logic [7:0] tbyte;
    logic       last;
  } lex_event_t;

  class lex_tracker;
    mode_t      mode;
    pos_t       line_no;
    pos_t       col_no;
    lex_event_t pending[$];
    lex_event_t step_ev[$];
    int         errors;

    function new();
      mode = MODE_IDLE;
      line_no = POS_ONE;
      col_no = POS_ONE;
      errors = 0;
    endfunction

    function void add(ev_kind_t k, tok_type_t t, pos_t l, pos_t c, logic [7:0] b);
      lex_event_t e;
      e.kind = k;
      e.ttype = t;
      e.line = l;
      e.col = c;
      e.tbyte = b;
      e.last = 1'b0;
      step_ev.insert(step_ev.size(), e);
    endfunction

    function void bump_col();
      if (col_no != POS_MAX) col_no++;
    endfunction

    function void bump_line();
      if (line_no != POS_MAX) line_no++;
      col_no = POS_ONE;
    endfunction

    function bit word_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == "_" || c == "." || c == "/" ||
             c == "-" || c == ":";
    endfunction

    function void single(tok_type_t t);
      add(EV_BEGIN, t, line_no, col_no, 8'h00);
      add(EV_END, t, '0, '0, 8'h00);
      bump_col();
    endfunction

    function void scan_idle(logic [7:0] c);
      mode = MODE_IDLE;
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
        bump_col();
      end else if (c == CH_LF) begin
        bump_line();
      end else if (c == CH_HASH) begin
        mode = MODE_COMMENT;
        bump_col();
      end else if (c == CH_LBRACE) begin
        single(TT_LBRACE);
      end else if (c == CH_RBRACE) begin
        single(TT_RBRACE);
      end else if (c == CH_SEMI) begin
        single(TT_SEMI);
      end else if (c == CH_QUOTE) begin
        add(EV_BEGIN, TT_STRING, line_no, col_no, 8'h00);
        bump_col();
        mode = MODE_STRING;
      end else begin
        add(EV_BEGIN, TT_IDENT, line_no, col_no, 8'h00);
        add(EV_TEXT, TT_IDENT, '0, '0, c);
        if (word_char(c)) mode = MODE_IDENT;
        else add(EV_END, TT_IDENT, '0, '0, 8'h00);
        bump_col();
      end
    endfunction

    function void note_byte(logic [7:0] c, logic eot);
      step_ev.delete();
      if (eot) begin
        case (mode)
          MODE_IDENT: add(EV_END, TT_IDENT, '0, '0, 8'h00);
          MODE_STRING: add(EV_END, TT_STRING, '0, '0, 8'h00);
          MODE_ESCAPE: begin
            add(EV_TEXT, TT_STRING, '0, '0, CH_BSLASH);
            add(EV_END, TT_STRING, '0, '0, 8'h00);
          end
          default: ;
        endcase
        add(EV_EOI, TT_IDENT, line_no, col_no, 8'h00);
        mode = MODE_IDLE;
      end else begin
        case (mode)
          MODE_COMMENT: begin
            if (c == CH_LF) begin
              mode = MODE_IDLE;
              bump_line();
            end else begin
              bump_col();
            end
          end
          MODE_IDENT: begin
            if (word_char(c)) begin
              add(EV_TEXT, TT_IDENT, '0, '0, c);
              bump_col();
            end else begin
              add(EV_END, TT_IDENT, '0, '0, 8'h00);
              scan_idle(c);
            end
          end
          MODE_STRING: begin
            if (c == CH_QUOTE) begin
              add(EV_END, TT_STRING, '0, '0, 8'h00);
              mode = MODE_IDLE;
            end else if (c == CH_BSLASH) begin
              mode = MODE_ESCAPE;
            end else begin
              add(EV_TEXT, TT_STRING, '0, '0, c);
            end
            bump_col();
          end
          MODE_ESCAPE: begin
            // only quote and backslash lose their escape
            if (c != CH_QUOTE && c != CH_BSLASH) add(EV_TEXT, TT_STRING, '0, '0, CH_BSLASH);
            add(EV_TEXT, TT_STRING, '0, '0, c);
            bump_col();
            mode = MODE_STRING;
          end
          default: scan_idle(c);
        endcase
      end
      if (step_ev.size() > 0) step_ev[step_ev.size()-1].last = 1'b1;
      foreach (step_ev[i]) pending.insert(pending.size(), step_ev[i]);
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    task check_event(input logic [1:0] kind, input logic [2:0] ttype, input pos_t line,
                     input pos_t col, input logic [7:0] tbyte, input logic last);
      lex_event_t e;
      if (pending.size() == 0) begin
        report_mismatch("word with none pending, kind", 32'(kind), '0);
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind) report_mismatch("event_kind", 32'(kind), 32'(e.kind));
      if (ttype !== e.ttype) report_mismatch("token_type", 32'(ttype), 32'(e.ttype));
      if (line !== e.line) report_mismatch("start_line", 32'(line), 32'(e.line));
      if (col !== e.col) report_mismatch("start_column", 32'(col), 32'(e.col));
      if (tbyte !== e.tbyte) report_mismatch("text_byte", 32'(tbyte), 32'(e.tbyte));
      if (last !== e.last) report_mismatch("last_result", 32'(last), 32'(e.last));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [1:0] out_event_kind;
  logic [2:0] out_token_type;
  pos_t       out_start_line;
  pos_t       out_start_column;
  logic [7:0] out_text_byte;
  logic       out_last_result;

  int send_idle_pct = 0;
  int pop_idle_pct = 0;
  int pop_hold = 0;
  int cycles = 0;
  int items_sent = 0;
  lex_tracker sb;

  config_text_tokenizer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_end_of_text   (in_end_of_text),
    .empty            (empty),
    .pop              (pop),
    .out_event_kind   (out_event_kind),
    .out_token_type   (out_token_type),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_text_byte    (out_text_byte),
    .out_last_result  (out_last_result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      sb.check_event(out_event_kind, out_token_type, out_start_line, out_start_column,
                     out_text_byte, out_last_result);
    end
    if (pop_hold > 0) begin
      pop_hold = pop_hold - 1;
      pop <= 1'b0;
    end else if ($urandom_range(0, 99) < pop_idle_pct) begin
      pop_hold = $urandom_range(0, 12);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eot);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 13);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(b, eot);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic wait_drained(input int settle);
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_word_char();
    logic [7:0] punct [5] = '{"_", ".", "/", "-", ":"};
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(48, 57));
      1: return 8'($urandom_range(65, 90));
      2: return 8'($urandom_range(97, 122));
      default: return punct[$urandom_range(0, 4)];
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0: return CH_TAB;
      1: return CH_CR;
      2: return CH_LF;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic int rand_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic send_random_token();
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(rand_word_char(), 1'b0);
        if ($urandom_range(0, 1)) send_item(rand_blank(), 1'b0);
      end
      6, 7, 8, 9: begin
        send_item(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) begin
            send_item(CH_BSLASH, 1'b0);
            case ($urandom_range(0, 2))
              0: c = CH_QUOTE;
              1: c = CH_BSLASH;
              default: c = 8'($urandom_range(0, 255));
            endcase
            send_item(c, 1'b0);
          end else begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_QUOTE || c == CH_BSLASH) c = CH_SPACE;
            send_item(c, 1'b0);
          end
        end
        case ($urandom_range(0, 9))
          0: send_item(8'($urandom_range(0, 255)), 1'b1);
          1: begin
            send_item(CH_BSLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
          end
          default: send_item(CH_QUOTE, 1'b0);
        endcase
      end
      10, 11, 12: begin
        case ($urandom_range(0, 2))
          0: send_item(CH_LBRACE, 1'b0);
          1: send_item(CH_RBRACE, 1'b0);
          default: send_item(CH_SEMI, 1'b0);
        endcase
      end
      13, 14: send_item(rand_blank(), 1'b0);
      15: begin
        send_item(CH_HASH, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_LF) c = CH_SPACE;
          send_item(c, 1'b0);
        end
        if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b1);
        else send_item(CH_LF, 1'b0);
      end
      16, 17: send_item(8'($urandom_range(0, 255)), 1'b0);
      18: send_item(8'($urandom_range(0, 255)), 1'b1);
      default: begin
        send_item(rand_word_char(), 1'b0);
        send_item(8'($urandom_range(128, 255)), 1'b0);
      end
    endcase
  endtask

  initial begin
    int target;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single tokens, identifier ends, escapes, open strings, end marks
    pop_idle_pct = 20;
    send_idle_pct = 10;
    send_text("{};Z9_ k");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_text("#x\n\"\\\"\\\\\\q\n\"\t\r\"\\");
    send_item(8'hFF, 1'b1);
    send_text("id");
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b1);

    repeat (5) begin
      send_idle_pct = rand_pct();
      pop_idle_pct = rand_pct();
      target = items_sent + 42;
      while (items_sent < target) send_random_token();
    end

    // no idling from here on
    send_idle_pct = 0;
    pop_idle_pct = 0;
    wait_drained(14);

    send_text("q{");
    send_item(8'h00, 1'b1);
    send_text("\nz");
    send_item(8'hFF, 1'b1);
    repeat (12) send_random_token();
    send_item(8'h00, 1'b1);
    wait_drained(20);

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/cttok_pkg.sv
sv/cttok_front.sv
sv/cttok_jobq.sv
sv/cttok_back.sv
sv/config_text_tokenizer.sv
test/tb.sv
